>>> rtl/button_debounce_press_classifier_unit_macros.svh
// assertion macros for the button debounce press classifier
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define BDPC_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication
`define BDPC_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> rtl/bdpc_pkg.sv
`timescale 1ns / 1ps
package bdpc_pkg;

   localparam int TIMER_WIDTH_DEF = 16;
   localparam int CFG_WIDTH = 16;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RST = 16'd50;
   localparam logic [CFG_WIDTH-1:0] HOLD_TICKS_RST = 16'd1000;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE_TICKS = 1'b0,
      CSR_HOLD_TICKS     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic pin_level;
      logic hold_accepted;
   } req_type;

   typedef struct packed {
      logic short_press;
      logic hold_event;
      logic held;
      logic stable_level;
   } rsp_type;

endpackage

>>> rtl/button_debounce_press_classifier_unit.sv
`timescale 1ns / 1ps
// Button debouncer with short-press and hold classification. Each request carries one raw
// active-low pin sample (one per tick) and the handler's hold answer; each request yields
// exactly one response with the short-press pulse, hold event, held flag and debounced
// level. A request is taken every clock cycle unless req_stall holds it back; it passes an
// input register and a result register, and its response is offered from the result
// register. Between the two registers sits the combinational state update (saturating
// timers, debounce and hold compares). Configuration writes (debounce_ticks, hold_ticks)
// are taken every cycle and must only be issued while no request is in flight. TIMER_WIDTH
// sets the width of both saturating timers (8 to 32).
module button_debounce_press_classifier_unit #(
   parameter int TIMER_WIDTH = bdpc_pkg::TIMER_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bdpc_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bdpc_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  bdpc_pkg::csr_index_type               csr_index,
   input  logic [bdpc_pkg::CFG_WIDTH-1:0]        csr_wdata
);
   import bdpc_pkg::*;

   `include "button_debounce_press_classifier_unit_macros.svh"

   localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

   logic [CFG_WIDTH-1:0]   debounce_ticks_ff;
   logic [CFG_WIDTH-1:0]   hold_ticks_ff;

   logic                   s1_valid_ff;
   req_type                s1_req_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   previous_raw_ff, previous_raw_in;
   logic                   debounced_level_ff, debounced_level_in;
   logic [TIMER_WIDTH-1:0] stable_count_ff, stable_count_in;
   logic                   press_active_ff, press_active_in;
   logic [TIMER_WIDTH-1:0] press_count_ff, press_count_in;
   logic                   hold_done_ff, hold_done_in;
   logic                   held_flag_ff, held_flag_in;
   rsp_type                rsp_in;

   logic                   s1_advance;
   logic                   s1_fire;
   logic                   req_fire;

   assign csr_ready   = 1'b1;
   assign s1_advance  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && s1_advance;
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign req_fire    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_TICKS_RST;
         hold_ticks_ff     <= HOLD_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
            CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_payload;
      end
   end

   // state update for the request in the input register
   always_comb begin
      logic [TIMER_WIDTH-1:0] pc;
      logic [TIMER_WIDTH-1:0] sc;
      logic                   raw;
      logic                   short_pulse;
      logic                   hold_ev;

      raw         = s1_req_ff.pin_level;
      short_pulse = 1'b0;
      hold_ev     = 1'b0;

      pc = press_count_ff;
      if (press_active_ff && (press_count_ff != {TIMER_WIDTH{1'b1}})) begin
         pc = press_count_ff + 1'b1;
      end

      if (raw != previous_raw_ff) begin
         sc = '0;
      end else if (stable_count_ff == {TIMER_WIDTH{1'b1}}) begin
         sc = stable_count_ff;
      end else begin
         sc = stable_count_ff + 1'b1;
      end

      debounced_level_in = debounced_level_ff;
      press_active_in    = press_active_ff;
      hold_done_in       = hold_done_ff;
      held_flag_in       = held_flag_ff;

      if ((CMP_WIDTH'(sc) > CMP_WIDTH'(debounce_ticks_ff)) && (raw != debounced_level_ff)) begin
         debounced_level_in = raw;
         if (!raw) begin
            press_active_in = 1'b1;
            pc              = '0;
         end else begin
            short_pulse     = press_active_ff && (CMP_WIDTH'(pc) < CMP_WIDTH'(hold_ticks_ff));
            press_active_in = 1'b0;
         end
      end
      previous_raw_in = raw;

      // finish a completed hold
      if (hold_done_ff) begin
         press_active_in = 1'b0;
         previous_raw_in = 1'b1;
         hold_done_in    = 1'b0;
      end

      // hold phase
      if (press_active_in && (CMP_WIDTH'(pc) >= CMP_WIDTH'(hold_ticks_ff))) begin
         if (!raw) begin
            held_flag_in = 1'b1;
            hold_ev      = 1'b1;
            hold_done_in = s1_req_ff.hold_accepted;
         end else begin
            hold_done_in = 1'b1;
            held_flag_in = 1'b0;
         end
      end

      stable_count_in = sc;
      press_count_in  = pc;

      rsp_in.short_press  = short_pulse;
      rsp_in.hold_event   = hold_ev;
      rsp_in.held         = held_flag_in;
      rsp_in.stable_level = debounced_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff    <= 1'b1;
         debounced_level_ff <= 1'b1;
         stable_count_ff    <= '0;
         press_active_ff    <= 1'b0;
         press_count_ff     <= '0;
         hold_done_ff       <= 1'b0;
         held_flag_ff       <= 1'b0;
      end else if (s1_fire) begin
         previous_raw_ff    <= previous_raw_in;
         debounced_level_ff <= debounced_level_in;
         stable_count_ff    <= stable_count_in;
         press_active_ff    <= press_active_in;
         press_count_ff     <= press_count_in;
         hold_done_ff       <= hold_done_in;
         held_flag_ff       <= held_flag_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   `BDPC_ASSERT_IMP(a_hold_implies_held, clock, reset,
      rsp_valid_ff && rsp_ff.hold_event, rsp_ff.held && !rsp_ff.stable_level)
   `BDPC_ASSERT_IMP(a_short_not_hold, clock, reset,
      rsp_valid_ff && rsp_ff.short_press, !rsp_ff.hold_event && rsp_ff.stable_level)
   `BDPC_ASSERT_NXT(a_hold_done_clears_press, clock, reset,
      s1_fire && hold_done_ff, !press_active_ff && previous_raw_ff)
   `BDPC_ASSERT_IMP(a_press_only_when_low, clock, reset,
      press_active_ff, !debounced_level_ff)

endmodule

>>> tb/tb_button_debounce_press_classifier_unit.sv
`timescale 1ns / 1ps
module tb_button_debounce_press_classifier_unit;
   import bdpc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   class press_scoreboard;
      logic [CFG_WIDTH-1:0] debounce_cfg;
      logic [CFG_WIDTH-1:0] hold_cfg;
      logic prev_raw;
      logic deb_level;
      logic press_on;
      logic hold_fin;
      logic held_q;
      logic [15:0] stable_cnt;
      logic [15:0] press_cnt;
      rsp_type expected_q[$];
      int errors;

      function new();
         debounce_cfg = DEBOUNCE_TICKS_RST;
         hold_cfg = HOLD_TICKS_RST;
         prev_raw = 1'b1;
         deb_level = 1'b1;
         press_on = 1'b0;
         hold_fin = 1'b0;
         held_q = 1'b0;
         stable_cnt = '0;
         press_cnt = '0;
         errors = 0;
      endfunction

      function logic [15:0] sat_inc(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function void apply_register(csr_index_type idx, logic [CFG_WIDTH-1:0] val);
         if (idx == CSR_DEBOUNCE_TICKS) begin
            debounce_cfg = val;
         end else begin
            hold_cfg = val;
         end
      endfunction

      // one tick of the debouncer and press classifier
      function void note_request(req_type r);
         logic raw;
         logic pulse;
         logic ev;
         rsp_type e;
         raw = r.pin_level;
         pulse = 1'b0;
         ev = 1'b0;
         if (press_on) press_cnt = sat_inc(press_cnt);
         if (raw != prev_raw) begin
            stable_cnt = '0;
         end else begin
            stable_cnt = sat_inc(stable_cnt);
         end
         if (stable_cnt > debounce_cfg && raw != deb_level) begin
            deb_level = raw;
            if (!raw) begin
               press_on = 1'b1;
               press_cnt = '0;
            end else begin
               if (press_on && press_cnt < hold_cfg) pulse = 1'b1;
               press_on = 1'b0;
            end
         end
         prev_raw = raw;
         // a finished hold clears the press one tick later
         if (hold_fin) begin
            press_on = 1'b0;
            prev_raw = 1'b1;
            hold_fin = 1'b0;
         end
         if (press_on && press_cnt >= hold_cfg) begin
            if (!raw) begin
               held_q = 1'b1;
               ev = 1'b1;
               hold_fin = r.hold_accepted;
            end else begin
               hold_fin = 1'b1;
               held_q = 1'b0;
            end
         end
         e.short_press = pulse;
         e.hold_event = ev;
         e.held = held_q;
         e.stable_level = deb_level;
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %b", a);
            return;
         end
         e = expected_q.pop_front();
         if (a.short_press !== e.short_press || a.hold_event !== e.hold_event ||
             a.held !== e.held || a.stable_level !== e.stable_level) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected short=%b hold_ev=%b held=%b level=%b",
                        e.short_press, e.hold_event, e.held, e.stable_level);
               $display("          actual   short=%b hold_ev=%b held=%b level=%b",
                        a.short_press, a.hold_event, a.held, a.stable_level);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_DEBOUNCE_TICKS;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   press_scoreboard sb = new();
   bit quiet = 1'b0;
   int cycle_count = 0;

   button_debounce_press_classifier_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 19);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_sample(input logic pin, input logic acc);
      req_type r;
      r.pin_level = pin;
      r.hold_accepted = acc;
      while (!quiet && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_register(idx, val);
   endtask

   // only reprogram once every request has drained
   task automatic program_timers(input int deb, input int hold);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(CSR_DEBOUNCE_TICKS, deb[CFG_WIDTH-1:0]);
      write_csr(CSR_HOLD_TICKS, hold[CFG_WIDTH-1:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // press and release sequences with bounce noise mixed in
   task automatic play_presses(input int n);
      int sent;
      int len;
      int cap;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(9) < 2) begin
            len = $urandom_range(1, 4);
            repeat (len) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
            sent += len;
         end else begin
            cap = int'(sb.debounce_cfg) + int'(sb.hold_cfg) + 4;
            if (cap > 60) cap = 60;
            len = $urandom_range(1, cap);
            repeat (len) send_sample($urandom_range(19) == 0, $urandom_range(3) == 0);
            sent += len;
            cap = int'(sb.debounce_cfg) + 4;
            if (cap > 40) cap = 40;
            len = $urandom_range(1, cap);
            repeat (len) send_sample($urandom_range(19) != 0, 1'($urandom_range(1)));
            sent += len;
         end
      end
   endtask

   int deb_list[8];
   int hold_list[8];

   initial begin
      deb_list = '{0, 1, 2, 3, 0, 65535, 0, 0};
      hold_list = '{1, 3, 6, 12, 65535, 1, 1, 1};
      deb_list[6] = $urandom_range(0, 4);
      hold_list[6] = $urandom_range(1, 16);
      deb_list[7] = $urandom_range(0, 6);
      hold_list[7] = $urandom_range(1, 24);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // low pin samples sent right after reset, under the reset timer settings
      repeat (3) send_sample(1'b0, 1'b0);

      program_timers(0, 3);
      // short press
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      // hold, handler accepts, press cleared, release without pulse
      repeat (5) send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      repeat (2) send_sample(1'b0, 1'b0);
      repeat (2) send_sample(1'b1, 1'b0);
      // pin rises during hold phase
      repeat (5) send_sample(1'b0, 1'b0);
      repeat (3) send_sample(1'b1, 1'b0);

      // hold phase from the press tick on
      program_timers(0, 0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      repeat (2) send_sample(1'b1, 1'b0);

      for (int i = 0; i < 8; i++) begin
         program_timers(deb_list[i], hold_list[i]);
         quiet = (i == 3);
         play_presses(160);
      end
      quiet = 1'b0;

      // long press through the hold phase
      program_timers(0, 40);
      repeat (50) send_sample(1'b0, 1'b0);
      repeat (20) send_sample(1'b0, 1'($urandom_range(1)));
      repeat (5) send_sample(1'b1, 1'b0);

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
